// File: design/rlebq_pkg.sv
// Shared constants, codes and types for the rate-limited event byte queue.
package rlebq_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int FILL_W       = PTR_W + 1;
    localparam int MAX_READ     = 64;
    localparam int CNT_W        = $clog2(MAX_READ + 1);
    localparam int TIME_W       = 32;
    localparam int INTERVAL_W   = 16;
    localparam int TAG_W        = 16;
    localparam int REQ_CNT_W    = 16;
    localparam int BYTE_W       = 8;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_READ);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_SEND,
        ST_EMPTY,
        ST_ERROR
    } state_t;

endpackage

// File: design/rlebq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rlebq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/rlebq_check.sv
// Delivery gate: pending request, data present and rate interval strictly exceeded.
module rlebq_check
    import rlebq_pkg::*;
(
    input  logic                  read_pending,
    input  logic [FILL_W-1:0]     fill_level,
    input  logic [TIME_W-1:0]     current_time,
    input  logic [TIME_W-1:0]     last_delivery_time,
    input  logic [INTERVAL_W-1:0] min_interval,
    output logic                  deliver_ok
);

    logic [TIME_W-1:0] elapsed;

    // Wrapping difference, so the comparison survives a time counter roll-over.
    assign elapsed    = current_time - last_delivery_time;
    assign deliver_ok = read_pending && (fill_level != '0)
                        && (elapsed > TIME_W'(min_interval));

endmodule

// File: design/rate_limited_event_byte_queue.sv
// Top level of the rate-limited event byte queue with its control sequencer.
//
// Usage: items arrive on the s_ channel (valid/ready) and carry an opcode: a
// byte write, a read request (tag and count, the count clamped to 64), a
// flush of the pending request by tag, or a time tick. Bytes go into a 4096
// byte circular store held in RAM; when the store is full the oldest byte is
// overwritten. A delivery check runs after a write that ends an event and
// after every tick; it answers the pending request once the store holds data
// and more than min_interval ticks have passed since the previous delivery.
// Results leave on the m_ channel (valid/ready) from an output register, and
// m_last marks the final result caused by one item.
// For each delivered byte the registered RAM read and the output load
// alternate, so a delivery keeps the sequencer busy until its last byte is loaded.
// s_ready is high only while the sequencer is idle; when the receiver stalls,
// the sequencer holds in its send, empty or error state until the output
// register frees up. The min_interval register is written on the cfg_ channel,
// always ready. Reset (aresetn, synchronous, active low) empties the queue,
// drops any pending request and clears both time counters; the store is not cleared.
module rate_limited_event_byte_queue
    import rlebq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INTERVAL_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_event_end,
    input  logic [TAG_W-1:0]      s_req_tag,
    input  logic [REQ_CNT_W-1:0]  s_read_count,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [TAG_W-1:0]      m_resp_tag,
    output logic [BYTE_W-1:0]     m_out_byte,
    output logic                  m_last
);

    state_t                state_reg, state_next;
    logic [INTERVAL_W-1:0] min_interval_reg;
    logic [PTR_W-1:0]      read_ptr_reg, read_ptr_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  pending_reg, pending_next;
    logic [TAG_W-1:0]      pend_tag_reg, pend_tag_next;
    logic [CNT_W-1:0]      pend_cnt_reg, pend_cnt_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic [TIME_W-1:0]     cur_time_reg, cur_time_next;
    logic [TIME_W-1:0]     last_time_reg, last_time_next;
    logic [TAG_W-1:0]      err_tag_reg, err_tag_next;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_kind_reg, m_kind_next;
    logic [TAG_W-1:0]      m_tag_reg, m_tag_next;
    logic [BYTE_W-1:0]     m_byte_reg, m_byte_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_we, ram_re;
    logic [PTR_W-1:0]      ram_waddr;
    logic [BYTE_W-1:0]     ram_rdata;
    logic                  deliver_ok;
    logic                  out_free;
    logic [CNT_W-1:0]      deliver_n;
    logic [CNT_W-1:0]      clamped_cnt;

    rlebq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_data_byte),
        .rd_en   (ram_re),
        .rd_addr (read_ptr_reg),
        .rd_data (ram_rdata)
    );

    rlebq_check u_check (
        .read_pending       (pending_reg),
        .fill_level         (fill_reg),
        .current_time       (cur_time_reg),
        .last_delivery_time (last_time_reg),
        .min_interval       (min_interval_reg),
        .deliver_ok         (deliver_ok)
    );

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_resp_tag = m_tag_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

    // The output register may take a new result when it is empty or being drained.
    assign out_free  = !m_valid_reg || m_ready;
    // New bytes land just past the newest stored byte; the add wraps at the store size.
    assign ram_waddr = read_ptr_reg + fill_reg[PTR_W-1:0];

    assign clamped_cnt = (s_read_count > REQ_CNT_W'(MAX_READ)) ? CNT_MAX
                                                               : s_read_count[CNT_W-1:0];
    assign deliver_n   = (FILL_W'(pend_cnt_reg) < fill_reg) ? pend_cnt_reg
                                                            : fill_reg[CNT_W-1:0];

    always_comb begin
        state_next     = state_reg;
        read_ptr_next  = read_ptr_reg;
        fill_next      = fill_reg;
        pending_next   = pending_reg;
        pend_tag_next  = pend_tag_reg;
        pend_cnt_next  = pend_cnt_reg;
        remain_next    = remain_reg;
        cur_time_next  = cur_time_reg;
        last_time_next = last_time_reg;
        err_tag_next   = err_tag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_tag_next     = m_tag_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (opcode_t'(s_opcode))
                        OP_WRITE: begin
                            ram_we = 1'b1;
                            if (fill_reg == FILL_FULL) begin
                                read_ptr_next = ram_waddr + PTR_W'(1);
                            end else begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            if (s_event_end) begin
                                state_next = ST_CHECK;
                            end
                        end
                        OP_READ: begin
                            if (pending_reg) begin
                                err_tag_next = s_req_tag;
                                state_next   = ST_ERROR;
                            end else begin
                                pending_next  = 1'b1;
                                pend_tag_next = s_req_tag;
                                pend_cnt_next = clamped_cnt;
                            end
                        end
                        OP_FLUSH: begin
                            if (pending_reg && (pend_tag_reg == s_req_tag)) begin
                                pending_next = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            cur_time_next = cur_time_reg + TIME_W'(1);
                            state_next    = ST_CHECK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (!deliver_ok) begin
                    state_next = ST_IDLE;
                end else if (deliver_n == '0) begin
                    state_next = ST_EMPTY;
                end else begin
                    remain_next = deliver_n;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_DATA;
                    m_tag_next    = pend_tag_reg;
                    m_byte_next   = ram_rdata;
                    m_last_next   = (remain_reg == CNT_W'(1));
                    read_ptr_next = read_ptr_reg + PTR_W'(1);
                    fill_next     = fill_reg - FILL_W'(1);
                    remain_next   = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        pending_next   = 1'b0;
                        last_time_next = cur_time_reg;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = KIND_EMPTY;
                    m_tag_next     = pend_tag_reg;
                    m_byte_next    = '0;
                    m_last_next    = 1'b1;
                    pending_next   = 1'b0;
                    last_time_next = cur_time_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_ERROR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ERROR;
                    m_tag_next   = err_tag_reg;
                    m_byte_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            min_interval_reg <= '0;
            read_ptr_reg     <= '0;
            fill_reg         <= '0;
            pending_reg      <= 1'b0;
            pend_tag_reg     <= '0;
            pend_cnt_reg     <= '0;
            remain_reg       <= '0;
            cur_time_reg     <= '0;
            last_time_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready) begin
                min_interval_reg <= cfg_data;
            end
            read_ptr_reg  <= read_ptr_next;
            fill_reg      <= fill_next;
            pending_reg   <= pending_next;
            pend_tag_reg  <= pend_tag_next;
            pend_cnt_reg  <= pend_cnt_next;
            remain_reg    <= remain_next;
            cur_time_reg  <= cur_time_next;
            last_time_reg <= last_time_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        err_tag_reg <= err_tag_next;
        m_kind_reg  <= m_kind_next;
        m_tag_reg   <= m_tag_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
    end

endmodule
